[rtl/core/key_press_classifier_macros.svh]
// Assertion macros for the key press classifier.
`ifndef KEY_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF
`define KPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define KPC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define KPC_ASSERT(lbl, clk, rst_n, prop)
`define KPC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[rtl/core/kpc_pkg.sv]
package kpc_pkg;

    localparam int NUM_KEYS_DEF = 32;
    localparam int KEY_IDX_W    = 5;
    localparam int CFG_IDX_W    = 8;

    localparam logic [15:0] LONG_THR_RST  = 16'd1000;
    localparam logic [15:0] SHORT_THR_RST = 16'd50;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MODE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MASK   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MASK    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MASK  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR    = 8'd7;

    // Previous level code meaning "not seen yet"
    localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_TOGGLE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] pin_levels;
        logic [31:0] now_ms;
    } t_scan;

    typedef struct packed {
        t_kind                event_kind;
        logic [KEY_IDX_W-1:0] key_index;
        logic                 toggle_level;
        logic                 last_event;
    } t_event;

    typedef struct packed {
        logic press_level;
        logic toggle_mode;
        logic short_en;
        logic long_en;
        logic toggle_en;
    } t_lane_cfg;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  level;
    } t_lane_evt;

endpackage

[rtl/core/kpc_lane.sv]
module kpc_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_step,
    input  logic               i_pin,
    input  logic [31:0]        i_now,
    input  kpc_pkg::t_lane_cfg i_cfg,
    input  logic [15:0]        i_long_thr,
    input  logic [15:0]        i_short_thr,
    output kpc_pkg::t_lane_evt o_evt
);
    import kpc_pkg::*;

    logic        r_held, n_held;
    logic [31:0] r_stamp, n_stamp;
    logic        r_latched, n_latched;
    logic [1:0]  r_prev, n_prev;

    logic        active;
    logic [31:0] dur;
    logic        ge_long;
    logic        ge_short;

    assign active   = (i_pin == i_cfg.press_level);
    assign dur      = i_now - r_stamp;
    assign ge_long  = (dur >= {16'd0, i_long_thr});
    assign ge_short = (dur >= {16'd0, i_short_thr});

    always_comb begin
        n_held    = r_held;
        n_stamp   = r_stamp;
        n_latched = r_latched;
        n_prev    = r_prev;
        o_evt     = '{valid: 1'b0, kind: KIND_SHORT, level: 1'b0};
        if (!i_cfg.toggle_mode) begin
            if (active && !r_held) begin
                n_held    = 1'b1;
                n_stamp   = i_now;
                n_latched = 1'b0;
            end else if (active) begin
                if (ge_long && !r_latched) begin
                    o_evt.valid = i_cfg.long_en;
                    o_evt.kind  = KIND_LONG;
                    n_latched   = 1'b1;
                end
            end else if (r_held) begin
                if (!ge_long && ge_short) begin
                    o_evt.valid = i_cfg.short_en;
                    o_evt.kind  = KIND_SHORT;
                end
                n_held = 1'b0;
            end
        end else begin
            if (r_prev != {1'b0, active}) begin
                n_prev    = {1'b0, active};
                n_stamp   = i_now;
                n_latched = 1'b0;
            end else if (!r_latched && ge_short) begin
                n_held      = active;
                o_evt.valid = i_cfg.toggle_en;
                o_evt.kind  = KIND_TOGGLE;
                o_evt.level = active;
                n_latched   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_held    <= 1'b0;
            r_stamp   <= '0;
            r_latched <= 1'b0;
            r_prev    <= LEVEL_UNKNOWN;
        end else if (i_step) begin
            r_held    <= n_held;
            r_stamp   <= n_stamp;
            r_latched <= n_latched;
            r_prev    <= n_prev;
        end
    end

endmodule

[rtl/core/kpc_merge.sv]
`include "key_press_classifier_macros.svh"

module kpc_merge #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  kpc_pkg::t_lane_evt i_evt [NUM_KEYS],
    output logic               o_busy,
    output logic               o_out_valid,
    output kpc_pkg::t_event    o_out_data,
    input  logic               i_out_stall
);
    import kpc_pkg::*;

    logic [NUM_KEYS-1:0] r_pend;
    t_kind               r_kind [NUM_KEYS];
    logic                r_lvl  [NUM_KEYS];
    logic                r_out_valid;
    t_event              r_out;

    logic [NUM_KEYS-1:0]  pick;
    logic [NUM_KEYS-1:0]  rest;
    logic [KEY_IDX_W-1:0] pick_idx;
    logic [1:0]           pick_kind;
    logic                 pick_lvl;
    logic                 adv;

    // Lowest pending key goes first
    assign pick = r_pend & (~r_pend + NUM_KEYS'(1));
    assign rest = r_pend & ~pick;
    assign adv  = (r_pend != '0) && (!r_out_valid || !i_out_stall);

    always_comb begin
        pick_idx  = '0;
        pick_kind = '0;
        pick_lvl  = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (pick[k]) begin
                pick_idx  = pick_idx | KEY_IDX_W'(k);
                pick_kind = pick_kind | r_kind[k];
                pick_lvl  = pick_lvl | r_lvl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    r_pend[k] <= i_evt[k].valid;
                end
            end else if (adv) begin
                r_pend <= rest;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_kind[k] <= i_evt[k].kind;
                r_lvl[k]  <= i_evt[k].level;
            end
        end
        if (adv) begin
            r_out.event_kind   <= t_kind'(pick_kind);
            r_out.key_index    <= pick_idx;
            r_out.toggle_level <= pick_lvl;
            r_out.last_event   <= (rest == '0);
        end
    end

    assign o_busy      = (r_pend != '0);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `KPC_ASSERT(a_load_only_empty, i_clk, i_rst_n, i_load |-> (r_pend == '0))
    `KPC_ASSERT(a_last_drains, i_clk, i_rst_n, (adv && rest == '0) |=> (r_pend == '0))
    `KPC_ASSERT(a_one_pick, i_clk, i_rst_n, (r_pend != '0) |-> $onehot(pick))
    `KPC_ASSERT_NEVER(a_no_bad_kind, i_clk, i_rst_n, r_out_valid && r_out.event_kind == 2'd3)

endmodule

[rtl/core/key_press_classifier.sv]
// Key press classifier.
// Input channel (i_in_valid / i_in_data / o_in_stall): one request per scan,
// carrying every key's pin level and the current time in milliseconds.
// Output channel (o_out_valid / o_out_data / i_out_stall): zero or more events
// per request, in ascending key order; last_event marks the final event of a scan.
// A scan that yields no event produces nothing on the output.
// Config channel (i_cfg_valid / i_cfg_index / i_cfg_data / o_cfg_ready): always
// ready; write only while no scan events are outstanding. Writing key_enable
// clears the state of every key whose enable bit flips.
// The per-key lanes evaluate a whole scan in its accept cycle; its events
// (at most NUM_KEYS, 32 by default) are queued then and move one at a time
// into the output register, one per cycle while the receiver does not stall,
// and the input is held until the queue is empty. The single event output
// sets the rate.
// The next scan is taken as soon as the last event has moved to the output
// register, even if that event still waits there.
// When the receiver stalls, the output register holds and the pending events
// stay queued; o_in_stall rises while any are pending.
// Reset clears all key state (previous level unknown), event queue and
// registers (thresholds go to 1000 ms long, 50 ms short).
module key_press_classifier #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  kpc_pkg::t_scan                    i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output kpc_pkg::t_event                   o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    output logic                              o_cfg_ready
);
    import kpc_pkg::*;

    logic [31:0] r_key_enable;
    logic [31:0] r_press_level;
    logic [31:0] r_toggle_mode;
    logic [31:0] r_short_mask;
    logic [31:0] r_long_mask;
    logic [31:0] r_toggle_mask;
    logic [15:0] r_long_thr;
    logic [15:0] r_short_thr;

    logic      cfg_wr;
    logic      en_wr;
    logic      in_acc;
    logic      busy;
    t_lane_evt lane_evt [NUM_KEYS];

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign en_wr       = cfg_wr && (i_cfg_index == REG_KEY_ENABLE);
    assign o_in_stall  = busy;
    assign in_acc      = i_in_valid && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable   <= '0;
            r_press_level  <= '0;
            r_toggle_mode  <= '0;
            r_short_mask   <= '0;
            r_long_mask    <= '0;
            r_toggle_mask  <= '0;
            r_long_thr     <= LONG_THR_RST;
            r_short_thr    <= SHORT_THR_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_KEY_ENABLE:   r_key_enable   <= i_cfg_data;
                REG_ACTIVE_LEVEL: r_press_level  <= i_cfg_data;
                REG_TOGGLE_MODE:  r_toggle_mode  <= i_cfg_data;
                REG_SHORT_MASK:   r_short_mask   <= i_cfg_data;
                REG_LONG_MASK:    r_long_mask    <= i_cfg_data;
                REG_TOGGLE_MASK:  r_toggle_mask  <= i_cfg_data;
                REG_LONG_THR:     r_long_thr     <= i_cfg_data[15:0];
                REG_SHORT_THR:    r_short_thr    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        t_lane_cfg lane_cfg;

        assign lane_cfg = '{
            press_level:  r_press_level[k],
            toggle_mode:  r_toggle_mode[k],
            short_en:     r_short_mask[k],
            long_en:      r_long_mask[k],
            toggle_en:    r_toggle_mask[k]
        };

        kpc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (en_wr && (r_key_enable[k] != i_cfg_data[k])),
            .i_step      (in_acc && r_key_enable[k]),
            .i_pin       (i_in_data.pin_levels[k]),
            .i_now       (i_in_data.now_ms),
            .i_cfg       (lane_cfg),
            .i_long_thr  (r_long_thr),
            .i_short_thr (r_short_thr),
            .o_evt       (lane_evt[k])
        );
    end

    // Disabled keys contribute no event
    t_lane_evt gated_evt [NUM_KEYS];

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            gated_evt[k]       = lane_evt[k];
            gated_evt[k].valid = lane_evt[k].valid && r_key_enable[k];
        end
    end

    kpc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_acc),
        .i_evt       (gated_evt),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import kpc_pkg::*;

    localparam int N_KEYS        = NUM_KEYS_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_SCANS   = 52;
    localparam logic [31:0] ALL_KEYS = 32'hFFFF_FFFF;
    // Pin pattern that reads as active for every key in the directed part
    localparam logic [31:0] PRESS_PINS = 32'hF0F0_F0F0;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_scan                in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_event               out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 cfg_ready;

    key_press_classifier u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the registers and the per-key state
    logic [31:0]       key_en_q;
    logic [31:0]       level_sel_q;
    logic [31:0]       toggle_sel_q;
    logic [31:0]       short_en_q;
    logic [31:0]       long_en_q;
    logic [31:0]       toggle_en_q;
    logic [15:0]       long_ms_q;
    logic [15:0]       short_ms_q;
    logic [N_KEYS-1:0] held_level;
    logic [31:0]       stamp_ms [N_KEYS];
    logic [N_KEYS-1:0] handled;
    logic [1:0]        seen_level [N_KEYS];

    t_scan  scan_backlog [$];
    t_event predicted_events [$];
    int     scans_sent    = 0;
    int     scans_taken   = 0;
    int     mismatch_count = 0;
    int     cycle_count   = 0;
    bit     calm          = 1'b0;
    int     gap_left      = 0;
    int     hold_left     = 0;

    function automatic void clear_key_state(int k);
        held_level[k] = 1'b0;
        stamp_ms[k]   = '0;
        handled[k]    = 1'b0;
        seen_level[k] = LEVEL_UNKNOWN;
    endfunction

    function automatic t_event make_event(t_kind kind, int k, logic lvl);
        t_event ev;
        ev.event_kind   = kind;
        ev.key_index    = KEY_IDX_W'(k);
        ev.toggle_level = lvl;
        ev.last_event   = 1'b0;
        return ev;
    endfunction

    // Advance the key state by one scan and queue the events it yields
    function automatic void classify_scan(t_scan s);
        t_event      found [N_KEYS];
        int          n;
        logic        act;
        logic [31:0] held_ms;
        n = 0;
        for (int k = 0; k < N_KEYS; k++) begin
            if (!key_en_q[k]) continue;
            act     = (s.pin_levels[k] == level_sel_q[k]);
            held_ms = s.now_ms - stamp_ms[k];
            if (!toggle_sel_q[k]) begin
                if (act && !held_level[k]) begin
                    held_level[k] = 1'b1;
                    stamp_ms[k]   = s.now_ms;
                    handled[k]    = 1'b0;
                end else if (act) begin
                    if (held_ms >= {16'd0, long_ms_q} && !handled[k]) begin
                        if (long_en_q[k]) begin
                            found[n] = make_event(KIND_LONG, k, 1'b0);
                            n++;
                        end
                        handled[k] = 1'b1;
                    end
                end else if (held_level[k]) begin
                    if (held_ms < {16'd0, long_ms_q} && held_ms >= {16'd0, short_ms_q}
                            && short_en_q[k]) begin
                        found[n] = make_event(KIND_SHORT, k, 1'b0);
                        n++;
                    end
                    held_level[k] = 1'b0;
                end
            end else begin
                if (seen_level[k] != {1'b0, act}) begin
                    seen_level[k] = {1'b0, act};
                    stamp_ms[k]   = s.now_ms;
                    handled[k]    = 1'b0;
                end else if (!handled[k] && held_ms >= {16'd0, short_ms_q}) begin
                    held_level[k] = act;
                    if (toggle_en_q[k]) begin
                        found[n] = make_event(KIND_TOGGLE, k, act);
                        n++;
                    end
                    handled[k] = 1'b1;
                end
            end
        end
        if (n > 0)
            found[n-1].last_event = 1'b1;
        for (int i = 0; i < n; i++)
            predicted_events.push_back(found[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void queue_scan(logic [31:0] pins, logic [31:0] now);
        t_scan s;
        s.pin_levels = pins;
        s.now_ms     = now;
        scan_backlog.push_back(s);
        scans_sent++;
    endfunction

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            REG_KEY_ENABLE: begin
                for (int k = 0; k < N_KEYS; k++)
                    if (key_en_q[k] != value[k])
                        clear_key_state(k);
                key_en_q = value;
            end
            REG_ACTIVE_LEVEL: level_sel_q  = value;
            REG_TOGGLE_MODE:  toggle_sel_q = value;
            REG_SHORT_MASK:   short_en_q   = value;
            REG_LONG_MASK:    long_en_q    = value;
            REG_TOGGLE_MASK:  toggle_en_q  = value;
            REG_LONG_THR:     long_ms_q    = value[15:0];
            REG_SHORT_THR:    short_ms_q   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_quiet();
        while (scans_taken != scans_sent || predicted_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 7);
                in_valid <= 1'b0;
            end else if (scan_backlog.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= scan_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted scan, check each accepted event
    always @(posedge i_clk) begin
        t_event want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                classify_scan(in_data);
                scans_taken++;
            end
            if (out_valid && !out_stall) begin
                if (predicted_events.size() == 0) begin
                    $error("event from key %0d with none expected", out_data.key_index);
                    mismatch_count++;
                end else begin
                    want = predicted_events.pop_front();
                    check_field("event_kind", want.event_kind, out_data.event_kind);
                    check_field("key_index", want.key_index, out_data.key_index);
                    check_field("toggle_level", want.toggle_level, out_data.toggle_level);
                    check_field("last_event", want.last_event, out_data.last_event);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("key_press_classifier regression: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] pins_now;
        logic [31:0] clock_ms;
        logic [31:0] flips;
        logic [31:0] long_v;
        logic [31:0] short_v;
        int          step_max;

        key_en_q     = '0;
        level_sel_q  = '0;
        toggle_sel_q = '0;
        short_en_q   = '0;
        long_en_q    = '0;
        toggle_en_q  = '0;
        long_ms_q    = LONG_THR_RST;
        short_ms_q   = SHORT_THR_RST;
        for (int k = 0; k < N_KEYS; k++)
            clear_key_state(k);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing enabled yet: no events
        queue_scan(ALL_KEYS, 32'd5);
        wait_quiet();

        // Low half press mode, high half toggle mode; thresholds 100 / 20
        write_reg(REG_KEY_ENABLE, ALL_KEYS);
        write_reg(REG_ACTIVE_LEVEL, PRESS_PINS);
        write_reg(REG_TOGGLE_MODE, 32'hFFFF_0000);
        write_reg(REG_SHORT_MASK, ALL_KEYS);
        write_reg(REG_LONG_MASK, ALL_KEYS);
        write_reg(REG_TOGGLE_MASK, ALL_KEYS);
        write_reg(REG_LONG_THR, 32'hABCD_0064);
        write_reg(REG_SHORT_THR, 32'h1234_0014);
        write_reg(CFG_IDX_W'(8), 32'hDEAD_BEEF);
        write_reg(CFG_IDX_W'(255), 32'h0000_0001);
        cfg_valid <= 1'b0;

        queue_scan(~PRESS_PINS, 32'd1000);
        queue_scan(PRESS_PINS, 32'd1000);
        queue_scan(PRESS_PINS, 32'd1020);           // toggle settles exactly at threshold
        queue_scan(~PRESS_PINS, 32'd1040);          // short presses
        queue_scan(~PRESS_PINS, 32'd1060);
        queue_scan(PRESS_PINS, 32'd1100);
        queue_scan(PRESS_PINS, 32'd1199);           // one below long
        queue_scan(PRESS_PINS, 32'd1200);           // long presses
        queue_scan(PRESS_PINS, 32'd1300);           // already latched
        queue_scan(~PRESS_PINS, 32'd1300);          // release after long: no short
        queue_scan(PRESS_PINS, 32'd1400);
        queue_scan(~PRESS_PINS, 32'd1419);          // bounce below debounce
        queue_scan(PRESS_PINS, 32'd1500);
        queue_scan(~PRESS_PINS, 32'd1599);          // longest short
        queue_scan(PRESS_PINS, 32'hFFFF_FFF0);
        queue_scan(~PRESS_PINS, 32'h0000_0010);     // hold spans the time wrap
        wait_quiet();

        // Partial masks, mode flip on live keys, enable change clears some keys
        write_reg(REG_SHORT_MASK, 32'h0000_5555);
        write_reg(REG_LONG_MASK, 32'h0000_AAAA);
        write_reg(REG_TOGGLE_MASK, 32'h5555_0000);
        write_reg(REG_TOGGLE_MODE, 32'h00FF_FF00);
        write_reg(REG_KEY_ENABLE, 32'h0F0F_FFFF);
        cfg_valid <= 1'b0;
        queue_scan(PRESS_PINS, 32'd5000);
        queue_scan(PRESS_PINS, 32'd5100);
        queue_scan(~PRESS_PINS, 32'd5200);
        queue_scan(~PRESS_PINS, 32'd5300);
        wait_quiet();

        // Zero thresholds
        write_reg(REG_KEY_ENABLE, ALL_KEYS);
        write_reg(REG_SHORT_MASK, ALL_KEYS);
        write_reg(REG_LONG_MASK, ALL_KEYS);
        write_reg(REG_TOGGLE_MASK, ALL_KEYS);
        write_reg(REG_TOGGLE_MODE, 32'hFFFF_0000);
        write_reg(REG_LONG_THR, 32'd0);
        write_reg(REG_SHORT_THR, 32'd0);
        cfg_valid <= 1'b0;
        queue_scan(PRESS_PINS, 32'd6000);
        queue_scan(PRESS_PINS, 32'd6000);
        queue_scan(~PRESS_PINS, 32'd6000);
        queue_scan(~PRESS_PINS, 32'd6000);

        pins_now = $urandom;
        clock_ms = $urandom;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_quiet();
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;

            case (p)
                1: begin long_v = 32'd65535; short_v = 32'd0; end
                2: begin long_v = 32'd0; short_v = 32'd0; end
                3, 7: begin long_v = $urandom; short_v = $urandom; end
                4: begin long_v = 32'd1000; short_v = 32'd50; end
                5: begin long_v = 32'd0; short_v = 32'd65535; end
                default: begin
                    long_v  = $urandom_range(20, 400);
                    short_v = $urandom_range(0, long_v);
                end
            endcase
            if (p != 3 && p != 7) begin
                long_v[31:16]  = $urandom;
                short_v[31:16] = $urandom;
            end

            if (p == 2)
                write_reg(REG_KEY_ENABLE, 32'd0);
            case ($urandom_range(0, 3))
                0: write_reg(REG_KEY_ENABLE, ALL_KEYS);
                1: write_reg(REG_KEY_ENABLE, $urandom);
                2: write_reg(REG_KEY_ENABLE, key_en_q ^ (32'd1 << $urandom_range(0, 31)));
                default: write_reg(REG_KEY_ENABLE, $urandom | 32'h0000_FFFF);
            endcase
            write_reg(REG_ACTIVE_LEVEL, $urandom);
            case ($urandom_range(0, 3))
                0: write_reg(REG_TOGGLE_MODE, 32'd0);
                1: write_reg(REG_TOGGLE_MODE, ALL_KEYS);
                default: write_reg(REG_TOGGLE_MODE, $urandom);
            endcase
            write_reg(REG_SHORT_MASK, ($urandom_range(0, 3) == 0) ? $urandom : ALL_KEYS);
            write_reg(REG_LONG_MASK, ($urandom_range(0, 3) == 0) ? $urandom : ALL_KEYS);
            write_reg(REG_TOGGLE_MASK, ($urandom_range(0, 3) == 0) ? $urandom : ALL_KEYS);
            write_reg(REG_LONG_THR, long_v);
            write_reg(REG_SHORT_THR, short_v);
            write_reg(CFG_IDX_W'($urandom_range(8, 255)), $urandom);
            cfg_valid <= 1'b0;

            // Step so that holds of a few scans straddle the thresholds
            step_max = ((long_ms_q > short_ms_q) ? long_ms_q : short_ms_q) / 4 + 3;
            for (int i = 0; i < PHASE_SCANS; i++) begin
                flips = '0;
                for (int b = 0; b < 32; b++)
                    if ($urandom_range(0, 5) == 0)
                        flips[b] = 1'b1;
                pins_now = pins_now ^ flips;
                clock_ms = clock_ms + $urandom_range(0, step_max);
                if ($urandom_range(0, 15) == 0)
                    pins_now = $urandom;
                if ($urandom_range(0, 31) == 0)
                    clock_ms = $urandom;
                queue_scan(pins_now, clock_ms);
            end
        end
        wait_quiet();
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("key_press_classifier regression: pass");
        else
            $display("key_press_classifier regression: fail");
        $finish;
    end

endmodule
